### rtl/detection_topk_box_decoder_top_defines.svh
// Assertion macros for the top-K box decoder.
// Included by the top level; depends on nothing else.
`ifndef DETECTION_TOPK_BOX_DECODER_TOP_DEFINES_SVH
`define DETECTION_TOPK_BOX_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DTKBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DTKBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DTKBD_ASSERT(lbl, prop, msg)
`define DTKBD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/dtkbd_pkg.sv
// Shared types, constants and the exp2 table of the top-K box decoder.
// Used by every module of the block; depends on nothing.
package dtkbd_pkg;

  localparam int unsigned MAX_TOPK    = 64;
  localparam int unsigned MAX_QUERIES = 512;
  localparam int unsigned MAX_CLASSES = 128;

  localparam logic [1:0] OP_LOAD_BOX   = 2'd0;
  localparam logic [1:0] OP_LOAD_LOGIT = 2'd1;
  localparam logic [1:0] OP_RUN        = 2'd2;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SCORE_THRESH = 3'd2;
  localparam logic [2:0] REG_TOP_COUNT    = 3'd3;
  localparam logic [2:0] REG_BACKGROUND   = 3'd4;
  localparam logic [2:0] REG_QUERY_COUNT  = 3'd5;
  localparam logic [2:0] REG_CLASS_COUNT  = 3'd6;

  // One kept candidate of the top-K list.
  typedef struct packed {
    logic               valid;
    logic signed [15:0] logit;
    logic [8:0]         query;
    logic [6:0]         cls;
  } entry_t;

  // Chain control broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic pop;
    logic flush;
  } cell_ctrl_t;

  // 2^(-i/16) in Q1.16 for i = 0..16.
  function automatic logic [16:0] exp2_tab(input logic [4:0] idx);
    logic [16:0] v;
    unique case (idx)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

### rtl/dtkbd_cell.sv
// One cell of the sorted top-K insertion chain.
// Depends on dtkbd_pkg for the entry and control types.
module dtkbd_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dtkbd_pkg::cell_ctrl_t  ctrl_i,
  input  dtkbd_pkg::entry_t      new_i,
  input  dtkbd_pkg::entry_t      prev_i,
  input  logic                   prev_beats_i,
  input  dtkbd_pkg::entry_t      next_i,
  output dtkbd_pkg::entry_t      cell_o,
  output logic                   beats_o
);

  dtkbd_pkg::entry_t cell_q, cell_d;

  // The new item outranks this cell if the cell is empty, its logit is
  // higher, or the logits tie and its flat index is lower.
  assign beats_o = !cell_q.valid || (new_i.logit > cell_q.logit) ||
                   ((new_i.logit == cell_q.logit) &&
                    ({new_i.query, new_i.cls} < {cell_q.query, cell_q.cls}));

  always_comb begin
    cell_d = cell_q;
    if (ctrl_i.flush) begin
      cell_d.valid = 1'b0;
    end else if (ctrl_i.pop) begin
      cell_d = next_i;
    end else if (ctrl_i.ins && beats_o) begin
      cell_d = prev_beats_i ? prev_i : new_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### rtl/dtkbd_sigmoid.sv
// Multi-cycle fixed-point sigmoid: exp2 interpolation, then a restoring
// divider that yields one quotient bit per cycle. Depends on dtkbd_pkg.
module dtkbd_sigmoid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] logit_i,
  output logic               done_o,
  output logic [15:0]        score_o
);

  typedef enum logic [1:0] {S_IDLE, S_EXP, S_PREP, S_DIV} sig_state_e;

  sig_state_e         state_q;
  logic [25:0]        prod_q;
  logic               neg_q;
  logic [16:0]        e_q;
  logic [9:0]         n_q;
  logic [16:0]        low_q;
  logic [18:0]        rem_q;
  logic [17:0]        div_q;
  logic [16:0]        quo_q;
  logic [4:0]         cnt_q;
  logic               done_q;
  logic [15:0]        score_q;

  logic signed [16:0] x_ext;
  logic [16:0]        a_abs;
  logic [17:0]        t_val;
  logic [9:0]         n_val;
  logic [16:0]        hi_v, lo_v, diff_v, e_v, z_v;
  logic [20:0]        interp;
  logic [17:0]        d_v;
  logic [33:0]        num_v, dividend;
  logic [18:0]        trial;
  logic [16:0]        quo_d;

  assign x_ext  = 17'(logit_i);
  assign a_abs  = x_ext[16] ? 17'(-x_ext) : 17'(x_ext);

  // First stage: table lookup and interpolation of the fractional exponent.
  assign t_val  = 18'((27'(prod_q) + 27'd128) >> 8);
  assign n_val  = t_val[17:8];
  assign hi_v   = dtkbd_pkg::exp2_tab({1'b0, t_val[7:4]});
  assign lo_v   = dtkbd_pkg::exp2_tab(5'({1'b0, t_val[7:4]}) + 5'd1);
  assign diff_v = hi_v - lo_v;
  assign interp = (diff_v[16:0] * 21'(t_val[3:0])) + 21'd8;
  assign e_v    = hi_v - 17'(interp >> 4);

  // Second stage: integer shift of the exponent and the divider operands.
  assign z_v    = (n_q >= 10'd17) ? 17'd0 : (e_q >> n_q[4:0]);
  assign d_v    = 18'd65536 + 18'(z_v);
  assign num_v  = neg_q ? {1'b0, z_v, 16'd0} : (34'd1 << 32);
  assign dividend = num_v + 34'(d_v >> 1);

  assign trial  = {rem_q[17:0], low_q[16]};
  assign quo_d  = {quo_q[15:0], trial >= 19'(div_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      prod_q  <= '0;
      neg_q   <= 1'b0;
      e_q     <= '0;
      n_q     <= '0;
      low_q   <= '0;
      rem_q   <= '0;
      div_q   <= '0;
      quo_q   <= '0;
      cnt_q   <= '0;
      score_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            prod_q  <= 26'(a_abs) * 26'd369;
            neg_q   <= logit_i[15];
            state_q <= S_EXP;
          end
        end
        S_EXP: begin
          e_q     <= e_v;
          n_q     <= n_val;
          state_q <= S_PREP;
        end
        S_PREP: begin
          // The quotient fits in 17 bits, so the top bits start the remainder.
          rem_q   <= {2'b00, dividend[33:17]};
          low_q   <= dividend[16:0];
          div_q   <= d_v;
          quo_q   <= '0;
          cnt_q   <= 5'd16;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= (trial >= 19'(div_q)) ? trial - 19'(div_q) : trial;
          low_q <= {low_q[15:0], 1'b0};
          quo_q <= quo_d;
          if (cnt_q == 5'd0) begin
            score_q <= quo_d[16] ? 16'hFFFF : quo_d[15:0];
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign score_o = score_q;

endmodule

### rtl/detection_topk_box_decoder_top.sv
// Top level of the top-K box decoder: box memory, insertion chain of cells,
// run sequencer and corner math. Depends on dtkbd_pkg, dtkbd_cell, dtkbd_sigmoid.
//
// Usage. An item is taken when start is high and busy is low. A box item
// writes one query's center box into a 512-entry memory. A logit item is
// offered to a chain of 64 cells that keeps the best logits in order; every
// cell compares the new item with its own entry in the same cycle and either
// keeps, takes its upper neighbor, or takes the new item, so logit items
// stream in at one per cycle and busy stays low for them.
// A run item raises busy. The sequencer then shifts the chain toward cell 0,
// one candidate at a time. A background candidate is skipped. Any other
// candidate leaves the chain, passes the sigmoid's table stages and its
// one-bit-per-cycle divider and hands back its score; survivors of the threshold
// then pass ST_CRN_A and ST_CRN_B of the corner math. A run ends with the list
// cleared and busy low. Results appear on the output ports for one cycle,
// marked by result_valid_o; one result is held back so that the final one can
// carry last. A run with no detection gives one marker with empty_run_o and
// last_o set. The receiver cannot stall. Configuration writes take effect at
// once; the user must make them only while busy is low, as the block does not
// enforce it. Reset clears the list and loads the default registers; the box
// memory holds no defined value until it is written.
`include "detection_topk_box_decoder_top_defines.svh"
module detection_topk_box_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic [8:0]         query_index_i,
  input  logic [6:0]         class_index_i,
  input  logic signed [15:0] class_logit_i,
  input  logic signed [15:0] center_x_i,
  input  logic signed [15:0] center_y_i,
  input  logic signed [15:0] box_w_i,
  input  logic signed [15:0] box_h_i,
  output logic               result_valid_o,
  output logic [15:0]        corner_x1_o,
  output logic [15:0]        corner_y1_o,
  output logic [15:0]        corner_x2_o,
  output logic [15:0]        corner_y2_o,
  output logic [15:0]        det_score_o,
  output logic [6:0]         dense_class_o,
  output logic [8:0]         source_query_o,
  output logic               empty_run_o,
  output logic               last_o
);

  localparam int unsigned NCELL = dtkbd_pkg::MAX_TOPK;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_POP, ST_SIG, ST_CRN_A, ST_CRN_B, ST_FINISH
  } run_state_e;

  typedef struct packed {
    logic [15:0] x1, y1, x2, y2;
    logic [15:0] score;
    logic [6:0]  dcls;
    logic [8:0]  query;
  } result_t;

  // Configuration registers.
  logic [11:0]        img_w_q, img_h_q;
  logic [15:0]        thresh_q;
  logic [6:0]         top_cnt_q;
  logic signed [7:0]  bg_q;
  logic [9:0]         qcnt_q;
  logic [7:0]         ccnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q   <= 12'd640;
      img_h_q   <= 12'd640;
      thresh_q  <= 16'd32768;
      top_cnt_q <= 7'd0;
      bg_q      <= -8'sd1;
      qcnt_q    <= 10'd300;
      ccnt_q    <= 8'd91;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dtkbd_pkg::REG_IMAGE_WIDTH:  img_w_q   <= cfg_data_i[11:0];
        dtkbd_pkg::REG_IMAGE_HEIGHT: img_h_q   <= cfg_data_i[11:0];
        dtkbd_pkg::REG_SCORE_THRESH: thresh_q  <= cfg_data_i;
        dtkbd_pkg::REG_TOP_COUNT:    top_cnt_q <= cfg_data_i[6:0];
        dtkbd_pkg::REG_BACKGROUND:   bg_q      <= cfg_data_i[7:0];
        dtkbd_pkg::REG_QUERY_COUNT:  qcnt_q    <= cfg_data_i[9:0];
        dtkbd_pkg::REG_CLASS_COUNT:  ccnt_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Effective query and class counts.
  logic [9:0] n_eff;
  logic [7:0] c_eff;
  assign n_eff = (qcnt_q > 10'(dtkbd_pkg::MAX_QUERIES)) ?
                 10'(dtkbd_pkg::MAX_QUERIES) : qcnt_q;
  assign c_eff = (ccnt_q > 8'(dtkbd_pkg::MAX_CLASSES)) ?
                 8'(dtkbd_pkg::MAX_CLASSES) : ccnt_q;

  run_state_e state_q;
  logic       accept;
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Insertion chain.
  dtkbd_pkg::cell_ctrl_t ctrl;
  dtkbd_pkg::entry_t     new_item;
  dtkbd_pkg::entry_t     cells  [NCELL];
  logic [NCELL-1:0]      beats;
  logic [NCELL-1:0]      valid_vec;
  logic [6:0]            idx_q, k_q;
  logic                  pop_now;

  assign new_item.valid = 1'b1;
  assign new_item.logit = class_logit_i;
  assign new_item.query = query_index_i;
  assign new_item.cls   = class_index_i;

  assign pop_now    = (state_q == ST_POP) && (idx_q < k_q) && cells[0].valid;
  assign ctrl.ins   = accept && (opcode_i == dtkbd_pkg::OP_LOAD_LOGIT) &&
                      ({1'b0, query_index_i} < n_eff) &&
                      ({1'b0, class_index_i} < c_eff);
  assign ctrl.pop   = pop_now;
  assign ctrl.flush = (state_q == ST_FINISH);

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    dtkbd_pkg::entry_t prev_e, next_e;
    logic              prev_b;
    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_b = 1'b0;
    end else begin : g_body
      assign prev_e = cells[i-1];
      assign prev_b = beats[i-1];
    end
    if (i == NCELL - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = cells[i+1];
    end
    dtkbd_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_i        (new_item),
      .prev_i       (prev_e),
      .prev_beats_i (prev_b),
      .next_i       (next_e),
      .cell_o       (cells[i]),
      .beats_o      (beats[i])
    );
    assign valid_vec[i] = cells[i].valid;
  end

  // Box memory: written by box items, read when a candidate leaves the chain.
  logic [63:0] box_mem [dtkbd_pkg::MAX_QUERIES];
  logic [63:0] box_rd_q;
  logic        box_we;
  assign box_we = accept && (opcode_i == dtkbd_pkg::OP_LOAD_BOX) &&
                  ({1'b0, query_index_i} < 10'(dtkbd_pkg::MAX_QUERIES));

  always_ff @(posedge clk_i) begin
    if (box_we) begin
      box_mem[query_index_i] <= {box_h_i, box_w_i, center_y_i, center_x_i};
    end
    if (pop_now) begin
      box_rd_q <= box_mem[cells[0].query];
    end
  end

  // Sigmoid unit.
  logic        sig_start, sig_done, bg_hit;
  logic [15:0] sig_score;
  assign bg_hit    = !bg_q[7] && (cells[0].cls == bg_q[6:0]);
  assign sig_start = pop_now && !bg_hit;

  dtkbd_sigmoid u_sigmoid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sig_start),
    .logit_i (cells[0].logit),
    .done_o  (sig_done),
    .score_o (sig_score)
  );

  // Corner lanes: x1, y1, x2, y2.
  logic signed [17:0] lane_s  [4];
  logic [11:0]        lane_sz [4];
  logic [15:0]        crn     [4];

  always_comb begin
    lane_s[0] = (18'(signed'(box_rd_q[15:0]))  <<< 1) - 18'(signed'(box_rd_q[47:32]));
    lane_s[1] = (18'(signed'(box_rd_q[31:16])) <<< 1) - 18'(signed'(box_rd_q[63:48]));
    lane_s[2] = (18'(signed'(box_rd_q[15:0]))  <<< 1) + 18'(signed'(box_rd_q[47:32]));
    lane_s[3] = (18'(signed'(box_rd_q[31:16])) <<< 1) + 18'(signed'(box_rd_q[63:48]));
    lane_sz[0] = img_w_q;
    lane_sz[1] = img_h_q;
    lane_sz[2] = img_w_q;
    lane_sz[3] = img_h_q;
  end

  for (genvar j = 0; j < 4; j++) begin : g_lane
    logic        pos_q;
    logic [28:0] prod_q;
    logic [18:0] rnd;
    logic [15:0] cap;
    always_ff @(posedge clk_i) begin
      if (state_q == ST_CRN_A) begin
        pos_q  <= (lane_s[j] > 18'sd0);
        prod_q <= 29'(lane_s[j][16:0]) * 29'(lane_sz[j]);
      end
    end
    assign rnd    = 19'((30'(prod_q) + 30'd1024) >> 11);
    assign cap    = {lane_sz[j], 4'd0};
    assign crn[j] = !pos_q ? 16'd0 : ((rnd > 19'(cap)) ? cap : rnd[15:0]);
  end

  // Run sequencer.
  logic [17:0] nc_prod;
  logic [9:0]  k_base;
  logic [17:0] k_min;
  assign nc_prod = 18'(n_eff) * 18'(c_eff);
  assign k_base  = (top_cnt_q != 7'd0) ? 10'(top_cnt_q) : n_eff;
  assign k_min   = (18'(k_base) < nc_prod) ? 18'(k_base) : nc_prod;

  dtkbd_pkg::entry_t head_q;
  logic [15:0]       score_q;
  result_t           pend_q, cur;
  logic              have_pend_q, kept;

  assign kept      = (crn[2] > crn[0]) && (crn[3] > crn[1]);
  assign cur.x1    = crn[0];
  assign cur.y1    = crn[1];
  assign cur.x2    = crn[2];
  assign cur.y2    = crn[3];
  assign cur.score = score_q;
  assign cur.dcls  = (!bg_q[7] && (head_q.cls > bg_q[6:0])) ?
                     head_q.cls - 7'd1 : head_q.cls;
  assign cur.query = head_q.query;

  result_t out_q;
  logic    out_v_q, out_empty_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      k_q         <= '0;
      head_q      <= '0;
      score_q     <= '0;
      pend_q      <= '0;
      have_pend_q <= 1'b0;
      out_q       <= '0;
      out_v_q     <= 1'b0;
      out_empty_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      out_v_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (opcode_i == dtkbd_pkg::OP_RUN)) begin
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          k_q         <= (k_min > 18'(NCELL)) ? 7'(NCELL) : k_min[6:0];
          idx_q       <= '0;
          have_pend_q <= 1'b0;
          state_q     <= ST_POP;
        end
        ST_POP: begin
          if (pop_now) begin
            idx_q <= idx_q + 7'd1;
            if (!bg_hit) begin
              head_q  <= cells[0];
              state_q <= ST_SIG;
            end
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_SIG: begin
          if (sig_done) begin
            score_q <= sig_score;
            state_q <= (sig_score < thresh_q) ? ST_POP : ST_CRN_A;
          end
        end
        ST_CRN_A: begin
          state_q <= ST_CRN_B;
        end
        ST_CRN_B: begin
          if (kept) begin
            if (have_pend_q) begin
              out_q       <= pend_q;
              out_v_q     <= 1'b1;
              out_empty_q <= 1'b0;
              out_last_q  <= 1'b0;
            end
            pend_q      <= cur;
            have_pend_q <= 1'b1;
          end
          state_q <= ST_POP;
        end
        ST_FINISH: begin
          out_v_q     <= 1'b1;
          out_last_q  <= 1'b1;
          out_empty_q <= !have_pend_q;
          out_q       <= have_pend_q ? pend_q : '0;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = out_v_q;
  assign corner_x1_o    = out_q.x1;
  assign corner_y1_o    = out_q.y1;
  assign corner_x2_o    = out_q.x2;
  assign corner_y2_o    = out_q.y2;
  assign det_score_o    = out_q.score;
  assign dense_class_o  = out_q.dcls;
  assign source_query_o = out_q.query;
  assign empty_run_o    = out_empty_q;
  assign last_o         = out_last_q;

  // The kept list stays packed from cell 0 upward.
  `DTKBD_ASSERT(a_chain_packed, ((valid_vec >> 1) & ~valid_vec) == '0, "chain has a hole")
  // An empty-run marker is always the last result of its run.
  `DTKBD_ASSERT(a_empty_is_last, result_valid_o && empty_run_o |-> last_o, "empty marker not last")
  // The block goes idle exactly as it delivers the final result of a run.
  `DTKBD_ASSERT(a_idle_on_last, $fell(busy) |-> (result_valid_o && last_o), "run ended without last")
  // Results come only from the corner stage or the end of a run.
  `DTKBD_ASSERT(a_result_src, result_valid_o |-> ($past(state_q) == ST_CRN_B || $past(state_q) == ST_FINISH), "stray result")

endmodule

### sim/tb_detection_topk_box_decoder_top.sv
// Self-checking testbench for the top-K box decoder: directed and random items,
// with a scoreboard class that predicts every detection.
// Depends on dtkbd_pkg and detection_topk_box_decoder_top.
module tb_detection_topk_box_decoder_top;

  // Opcode that the block must ignore.
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  // One command item as driven on the input ports.
  typedef struct {
    logic [1:0]         op;
    logic [8:0]         q;
    logic [6:0]         c;
    logic signed [15:0] lg;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] w;
    logic signed [15:0] h;
  } cmd_t;

  // One detection as seen on the result ports.
  typedef struct {
    logic [15:0] x1;
    logic [15:0] y1;
    logic [15:0] x2;
    logic [15:0] y2;
    logic [15:0] score;
    logic [6:0]  dc;
    logic [8:0]  sq;
    logic        empty;
    logic        last;
  } det_t;

  // The scoreboard keeps its own copy of the registers, the ranked list and the
  // box memory, and turns each run item into the detections it must produce.
  class topk_scoreboard;
    logic [11:0] img_w, img_h;
    logic [15:0] thresh;
    logic [6:0]  top_cnt;
    logic [7:0]  bg_raw;
    logic [9:0]  q_cnt;
    logic [7:0]  c_cnt;
    logic signed [15:0] rank_logit [dtkbd_pkg::MAX_TOPK];
    logic [8:0]  rank_query [dtkbd_pkg::MAX_TOPK];
    logic [6:0]  rank_class [dtkbd_pkg::MAX_TOPK];
    bit          rank_valid [dtkbd_pkg::MAX_TOPK];
    logic [63:0] box_mem [dtkbd_pkg::MAX_QUERIES];
    det_t        pending_dets [$];
    int          errors;

    function new();
      img_w = 640; img_h = 640; thresh = 32768; top_cnt = 0;
      bg_raw = 8'hFF; q_cnt = 300; c_cnt = 91; errors = 0;
      foreach (rank_valid[i]) begin
        rank_valid[i] = 0; rank_logit[i] = 0; rank_query[i] = 0; rank_class[i] = 0;
      end
    endfunction

    function void configure(logic [2:0] idx, logic [15:0] data);
      case (idx)
        dtkbd_pkg::REG_IMAGE_WIDTH:  img_w = data[11:0];
        dtkbd_pkg::REG_IMAGE_HEIGHT: img_h = data[11:0];
        dtkbd_pkg::REG_SCORE_THRESH: thresh = data;
        dtkbd_pkg::REG_TOP_COUNT:    top_cnt = data[6:0];
        dtkbd_pkg::REG_BACKGROUND:   bg_raw = data[7:0];
        dtkbd_pkg::REG_QUERY_COUNT:  q_cnt = data[9:0];
        dtkbd_pkg::REG_CLASS_COUNT:  c_cnt = data[7:0];
        default: ;
      endcase
    endfunction

    function int eff_queries();
      return q_cnt < dtkbd_pkg::MAX_QUERIES ? int'(q_cnt) : dtkbd_pkg::MAX_QUERIES;
    endfunction

    function int eff_classes();
      return c_cnt < dtkbd_pkg::MAX_CLASSES ? int'(c_cnt) : dtkbd_pkg::MAX_CLASSES;
    endfunction

    function longint exp2_neg(longint idx);
      longint tab [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                           46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219,
                           32768};
      return tab[idx];
    endfunction

    // Logistic score in Q0.16 from a Q8.8 logit, via a base-2 exponential.
    function logic [15:0] score_of(logic signed [15:0] x);
      longint a, t, n, f, hi, lo, e, z, d, num, p;
      a = x < 0 ? -longint'(x) : longint'(x);
      t = (a * 369 + 128) >>> 8;
      n = t >>> 8;
      f = t & 255;
      hi = exp2_neg(f >>> 4);
      lo = exp2_neg((f >>> 4) + 1);
      e = hi - ((hi - lo) * (f & 15) + 8) / 16;
      z = n >= 17 ? 0 : (e >>> n);
      d = 65536 + z;
      num = x >= 0 ? 64'h1_0000_0000 : (z << 16);
      p = (num + d / 2) / d;
      return p > 65535 ? 16'hFFFF : p[15:0];
    endfunction

    function logic [15:0] pixel_edge(longint s, longint size);
      longint p;
      if (s <= 0) return 0;
      p = (s * size + 1024) >>> 11;
      return p > (size << 4) ? 16'(size << 4) : p[15:0];
    endfunction

    function void rank_insert(logic [8:0] q, logic [6:0] c, logic signed [15:0] lg);
      int pos;
      logic [15:0] key, ck;
      key = {q, c};
      pos = 0;
      while (pos < dtkbd_pkg::MAX_TOPK && rank_valid[pos]) begin
        ck = {rank_query[pos], rank_class[pos]};
        if (lg > rank_logit[pos] || (lg == rank_logit[pos] && key < ck)) break;
        pos++;
      end
      if (pos >= dtkbd_pkg::MAX_TOPK) return;
      for (int j = dtkbd_pkg::MAX_TOPK - 1; j > pos; j--) begin
        rank_logit[j] = rank_logit[j-1]; rank_query[j] = rank_query[j-1];
        rank_class[j] = rank_class[j-1]; rank_valid[j] = rank_valid[j-1];
      end
      rank_logit[pos] = lg; rank_query[pos] = q; rank_class[pos] = c;
      rank_valid[pos] = 1;
    endfunction

    function void decode_run();
      int n, cls, k, bg, cnt;
      det_t d;
      logic [63:0] b;
      logic signed [15:0] cx, cy, w, h;
      n = eff_queries();
      cls = eff_classes();
      k = top_cnt != 0 ? int'(top_cnt) : n;
      if (k > n * cls) k = n * cls;
      if (k > dtkbd_pkg::MAX_TOPK) k = dtkbd_pkg::MAX_TOPK;
      bg = int'($signed(bg_raw));
      cnt = 0;
      for (int i = 0; i < k; i++) begin
        if (!rank_valid[i]) break;
        if (bg >= 0 && int'(rank_class[i]) == bg) continue;
        d.score = score_of(rank_logit[i]);
        if (d.score < thresh) continue;
        b = box_mem[rank_query[i]];
        cx = b[15:0]; cy = b[31:16]; w = b[47:32]; h = b[63:48];
        d.x1 = pixel_edge(2 * longint'(cx) - longint'(w), img_w);
        d.x2 = pixel_edge(2 * longint'(cx) + longint'(w), img_w);
        d.y1 = pixel_edge(2 * longint'(cy) - longint'(h), img_h);
        d.y2 = pixel_edge(2 * longint'(cy) + longint'(h), img_h);
        if (!(d.x2 > d.x1 && d.y2 > d.y1)) continue;
        d.dc = (bg >= 0 && int'(rank_class[i]) > bg) ? rank_class[i] - 7'd1 : rank_class[i];
        d.sq = rank_query[i];
        d.empty = 0;
        d.last = 0;
        pending_dets.insert(pending_dets.size(), d);
        cnt++;
      end
      if (cnt == 0) begin
        d = '{default: 0};
        d.empty = 1;
        d.last = 1;
        pending_dets.insert(pending_dets.size(), d);
      end else begin
        pending_dets[pending_dets.size() - 1].last = 1;
      end
      foreach (rank_valid[i]) rank_valid[i] = 0;
    endfunction

    // Called for every accepted input item.
    function void note_item(cmd_t t);
      case (t.op)
        dtkbd_pkg::OP_LOAD_BOX:   box_mem[t.q] = {t.h, t.w, t.cy, t.cx};
        dtkbd_pkg::OP_LOAD_LOGIT: if (int'(t.q) < eff_queries() && int'(t.c) < eff_classes())
                                    rank_insert(t.q, t.c, t.lg);
        dtkbd_pkg::OP_RUN:        decode_run();
        default: ;
      endcase
    endfunction

    function void compare(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Called for every result strobe.
    function void check_detection(det_t r);
      det_t e;
      if (pending_dets.size() == 0) begin
        $error("unexpected result: query %0d class %0d", r.sq, r.dc);
        errors++;
        return;
      end
      e = pending_dets.pop_front();
      compare("corner_x1", e.x1, r.x1);
      compare("corner_y1", e.y1, r.y1);
      compare("corner_x2", e.x2, r.x2);
      compare("corner_y2", e.y2, r.y2);
      compare("det_score", e.score, r.score);
      compare("dense_class", e.dc, r.dc);
      compare("source_query", e.sq, r.sq);
      compare("empty_run", e.empty, r.empty);
      compare("last", e.last, r.last);
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic start = 0;
  logic busy;
  logic [1:0] opcode_i = '0;
  logic [8:0] query_index_i = '0;
  logic [6:0] class_index_i = '0;
  logic signed [15:0] class_logit_i = '0, center_x_i = '0, center_y_i = '0;
  logic signed [15:0] box_w_i = '0, box_h_i = '0;
  logic result_valid_o;
  logic [15:0] corner_x1_o, corner_y1_o, corner_x2_o, corner_y2_o, det_score_o;
  logic [6:0] dense_class_o;
  logic [8:0] source_query_o;
  logic empty_run_o, last_o;

  topk_scoreboard sb = new();
  bit box_loaded [dtkbd_pkg::MAX_QUERIES];
  int idle_pct = 0;
  int n_sent = 0;

  always #1 clk_i = ~clk_i;

  detection_topk_box_decoder_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start, .busy,
    .opcode_i, .query_index_i, .class_index_i, .class_logit_i,
    .center_x_i, .center_y_i, .box_w_i, .box_h_i,
    .result_valid_o, .corner_x1_o, .corner_y1_o, .corner_x2_o, .corner_y2_o,
    .det_score_o, .dense_class_o, .source_query_o, .empty_run_o, .last_o
  );

  // Results cannot be held off, so every strobe is checked at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check_detection('{corner_x1_o, corner_y1_o, corner_x2_o, corner_y2_o,
                           det_score_o, dense_class_o, source_query_o,
                           empty_run_o, last_o});
  end

  // Drives one item, with an optional random gap first, and waits for the edge that takes it.
  task automatic send(cmd_t t);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start <= 1;
    opcode_i <= t.op; query_index_i <= t.q; class_index_i <= t.c;
    class_logit_i <= t.lg; center_x_i <= t.cx; center_y_i <= t.cy;
    box_w_i <= t.w; box_h_i <= t.h;
    do @(posedge clk_i); while (busy);
    sb.note_item(t);
    n_sent++;
    if (t.op == dtkbd_pkg::OP_LOAD_BOX) box_loaded[t.q] = 1;
  endtask

  task automatic load_box(int q, int cx, int cy, int w, int h);
    send('{dtkbd_pkg::OP_LOAD_BOX, 9'(q), 7'($urandom), 16'($urandom), 16'(cx),
           16'(cy), 16'(w), 16'(h)});
  endtask

  task automatic random_box(int q);
    if ($urandom_range(9) < 2)
      load_box(q, $urandom, $urandom, $urandom, $urandom);
    else
      load_box(q, $urandom_range(0, 16384), $urandom_range(0, 16384),
               $urandom_range(0, 12000), $urandom_range(0, 12000));
  endtask

  // A logit for a query that can reach the list must have its box loaded first,
  // since the box memory has no defined contents until written.
  task automatic load_logit(int q, int c, int lg);
    if (q < sb.eff_queries() && c < sb.eff_classes() && !box_loaded[q]) random_box(q);
    send('{dtkbd_pkg::OP_LOAD_LOGIT, 9'(q), 7'(c), 16'(lg), 16'($urandom),
           16'($urandom), 16'($urandom), 16'($urandom)});
  endtask

  task automatic run_decode();
    send('{dtkbd_pkg::OP_RUN, 9'($urandom), 7'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom), 16'($urandom), 16'($urandom)});
  endtask

  // Waits until the block is idle and every expected detection has come out.
  task automatic drain();
    start <= 0;
    @(posedge clk_i);
    while (sb.pending_dets.size() != 0 || busy) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, int data);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= 16'(data);
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.configure(idx, 16'(data));
  endtask

  task automatic set_config(int iw, int ih, int thr, int topc, int bg, int qc, int cc);
    write_reg(dtkbd_pkg::REG_IMAGE_WIDTH, iw);
    write_reg(dtkbd_pkg::REG_IMAGE_HEIGHT, ih);
    write_reg(dtkbd_pkg::REG_SCORE_THRESH, thr);
    write_reg(dtkbd_pkg::REG_TOP_COUNT, topc);
    write_reg(dtkbd_pkg::REG_BACKGROUND, bg & 8'hFF);
    write_reg(dtkbd_pkg::REG_QUERY_COUNT, qc);
    write_reg(dtkbd_pkg::REG_CLASS_COUNT, cc);
  endtask

  // One frame: a batch of logits, mostly valid, with ties, duplicates and noise,
  // then a run. The batch stops early once the item count reaches stop.
  task automatic random_frame(int stop);
    int n, cls, count, q, c, lg, pick;
    n = sb.eff_queries();
    cls = sb.eff_classes();
    count = ($urandom_range(9) < 2) ? $urandom_range(60, 100) : $urandom_range(1, 30);
    for (int i = 0; i < count && n_sent < stop; i++) begin
      pick = $urandom_range(99);
      q = $urandom_range(0, n - 1);
      c = $urandom_range(0, cls - 1);
      lg = (pick < 20) ? $urandom_range(0, 3) * 128 : $urandom;
      if (pick >= 95) begin
        send('{OP_UNKNOWN, 9'($urandom), 7'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom), 16'($urandom)});
      end else if (pick >= 90) begin
        load_logit($urandom_range(0, 511), $urandom_range(0, 127), $urandom);
      end else if (pick >= 80) begin
        random_box(q);
      end else begin
        load_logit(q, c, lg);
      end
    end
    run_decode();
  endtask

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int budget;
    int phase_idle [6] = '{0, 62, 0, 28, 62, 0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed part at the reset settings: box extremes, logit extremes,
    // an equal-logit tie, a duplicate, ignored items, then a run and an empty run.
    load_box(0, 8192, 8192, 4096, 4096);
    load_box(1, -32768, 32767, 32767, -32768);
    load_box(2, 16384, 16384, 32767, 32767);
    load_box(3, 8000, 8000, 0, 4000);
    load_box(511, 32767, -32768, -32768, 32767);
    load_logit(0, 0, 32767);
    load_logit(0, 1, -32768);
    load_logit(1, 2, 0);
    load_logit(0, 3, 0);
    load_logit(2, 5, 256);
    load_logit(3, 1, 512);
    load_logit(0, 0, 32767);
    load_logit(400, 0, 1000);
    load_logit(5, 100, 1000);
    send('{OP_UNKNOWN, 9'h1FF, 7'h7F, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1});
    run_decode();
    run_decode();
    drain();

    // Random part over several register settings, extremes among them.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(4095, 4095, 0, 64, 0, 512, 128);
        1: set_config(1, 1, 65535, 1, 127, 1, 1);
        2: set_config(0, 300, 20000, 127, 5, 20, 10);
        3: set_config(1920, 1080, 40000, 10, 3, 1023, 255);
        4: set_config(800, 600, 16384, 0, -1, 16, 4);
        default: set_config(320, 240, 32768, 32, 2, 40, 3);
      endcase
      idle_pct = phase_idle[p];
      budget = n_sent + 38;
      while (n_sent < budget) begin
        random_frame(budget);
      end
      drain();
    end

    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
